@@ src/frame_rms_voice_detector_assert.svh @@
// ----------------------------------------------------------------------------
// frame rms voice detector assertion macros
// shorthand for clocked checks, reset-qualified on rst_n
// ----------------------------------------------------------------------------
`ifndef FRAME_RMS_VOICE_DETECTOR_ASSERT_SVH
`define FRAME_RMS_VOICE_DETECTOR_ASSERT_SVH

// same-cycle implication
`define FRVD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FRVD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/frvd_pkg.sv @@
// ----------------------------------------------------------------------------
// frvd_pkg
// shared types and constants of the frame rms voice detector
// ----------------------------------------------------------------------------
`default_nettype none

package frvd_pkg;

  localparam int SAMPLE_W      = 32;
  localparam int SAMPLE_SHIFT  = 8;
  localparam int MAG_W         = SAMPLE_W - SAMPLE_SHIFT;  // 24
  localparam int SQ_W          = 2 * MAG_W - 1;            // largest square is 2**46
  localparam int ROOT_W        = 24;
  localparam int LEVEL_W       = 24;
  localparam int THR_W         = 23;
  localparam int HANG_W        = 8;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 23;
  localparam int FRAME_MAX_DEF = 1024;

  localparam logic [HANG_W-1:0] HANG_RESET = 8'd20;
  localparam logic [HANG_W-1:0] SIL_MAX    = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_HANGOVER  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ACCUM,
    S_DIVIDE,
    S_ROOT,
    S_EMIT
  } seq_state_t;

  // per-cycle commands from the sequencer to the datapath
  typedef struct packed {
    logic load;      // sample word taken
    logic square;    // multiplier result captured
    logic accum;     // add square into running sum
    logic divide;    // one restoring divide step
    logic div_last;  // final divide step
    logic root;      // one square root digit step
    logic emit;      // result written to output register
  } ctl_t;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

@@ src/frvd_alu.sv @@
// ----------------------------------------------------------------------------
// frvd_alu
// shared adder / subtractor, borrow flag doubles as the compare result
// ----------------------------------------------------------------------------
`default_nettype none

module frvd_alu import frvd_pkg::*; #(
  parameter int W = SQ_W + $clog2(FRAME_MAX_DEF) + 1
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic         sub,
  output logic      [W-1:0] res,
  output logic              borrow
);

  logic [W:0] sum;

  always_comb begin
    sum    = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
    res    = sum[W-1:0];
    borrow = sub & ~sum[W];
  end

endmodule

`default_nettype wire

@@ src/frvd_seq.sv @@
// ----------------------------------------------------------------------------
// frvd_seq
// sequencer: sample accumulate steps, divide loop, square root loop, emit
// ----------------------------------------------------------------------------
`default_nettype none

module frvd_seq import frvd_pkg::*; #(
  parameter int DIV_STEPS  = SQ_W + $clog2(FRAME_MAX_DEF) + 1,
  parameter int ROOT_STEPS = ROOT_W
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic close,
  input  wire logic out_busy,
  output logic      in_ready,
  output ctl_t      ctl
);

  localparam int STEP_W = $clog2(max2(max2(DIV_STEPS, ROOT_STEPS), 2));

  seq_state_t          state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_SQUARE;
        end
      end
      S_SQUARE: begin
        ctl.square = 1'b1;
        state_nxt  = S_ACCUM;
      end
      S_ACCUM: begin
        ctl.accum = 1'b1;
        step_nxt  = '0;
        state_nxt = close ? S_DIVIDE : S_IDLE;
      end
      S_DIVIDE: begin
        ctl.divide = 1'b1;
        step_nxt   = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          ctl.div_last = 1'b1;
          step_nxt     = '0;
          state_nxt    = S_ROOT;
        end
      end
      S_ROOT: begin
        ctl.root = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(ROOT_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_busy) begin
          ctl.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ src/frame_rms_voice_detector.sv @@
// Frame RMS voice detector. Each input word carries one signed 32-bit
// microphone sample; its upper 24 bits are squared and summed over the frame.
// A frame closes on the word with frame_last set, or at FRAME_MAX samples.
// A closed frame yields one output word: level = floor(sqrt(sum / count)),
// plus voice_now / voice_start / voice_end from a threshold detector with a
// hangover of hangover_frames quiet frames. Processing: a sample that does not
// close a frame goes through accept, 24x24 square and accumulate. A closing
// sample adds one shared add/subtract unit run as a restoring divider for
// max(SUM_W, 48) steps (58 at FRAME_MAX = 1024) then as a digit-by-digit
// square root for 24 steps, then loads the output register once the
// previous output word has been taken. in_ready is low while a sample is
// being worked on.
// Configuration: cfg index 0 is voice_threshold, index 1 is hangover_frames;
// cfg_ready is always high, writes are meant to happen while the block idles.
// ----------------------------------------------------------------------------
// frame_rms_voice_detector
// top level: handshakes, config registers, datapath around the shared unit
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_rms_voice_detector_assert.svh"

module frame_rms_voice_detector import frvd_pkg::*; #(
  parameter int FRAME_MAX = FRAME_MAX_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // sample words
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic                  in_frame_last,
  // result words
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [LEVEL_W-1:0]         out_level,
  output logic                       out_voice_now,
  output logic                       out_voice_start,
  output logic                       out_voice_end,
  // register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // sample counter holds 0..FRAME_MAX-1 between samples, up to FRAME_MAX at close
  localparam int CNT_W   = $clog2(FRAME_MAX + 1);
  localparam int SUM_W   = SQ_W + $clog2(FRAME_MAX) + 1;
  // divide shift register also carries the square root radicand
  localparam int QREG_W  = max2(SUM_W, 2 * ROOT_W);
  // partial remainder wide enough for both the divide and the root loop
  localparam int REM_W   = max2(CNT_W + 1, ROOT_W + 2);
  localparam int ALU_W   = max2(SUM_W, REM_W);

  // config registers
  logic [THR_W-1:0]  thresh_r;
  logic [HANG_W-1:0] hang_r;

  // datapath registers
  logic [MAG_W-1:0]  mag_r;
  logic [SQ_W-1:0]   sq_r;
  logic [SUM_W-1:0]  sum_r,   sum_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  div_r,   div_nxt;
  logic [QREG_W-1:0] quo_r,   quo_nxt;
  logic [REM_W-1:0]  rem_r,   rem_nxt;
  logic [ROOT_W-1:0] root_r,  root_nxt;
  logic              close_r;

  // detector state
  logic              speaking_r, speaking_nxt;
  logic [HANG_W-1:0] silence_r,  silence_nxt;

  // output register
  logic              out_valid_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic              out_now_r, out_start_r, out_end_r;
  logic              vnow, vstart, vend;

  // shared unit hookup
  logic [ALU_W-1:0]  alu_a, alu_b, alu_res;
  logic              alu_sub, alu_borrow;
  logic [REM_W-1:0]  div_trial, root_trial, root_take;

  logic [MAG_W-1:0]  top_bits;
  logic              in_fire;
  ctl_t              ctl;

  // the sequencer raises load exactly when a sample word is accepted
  assign in_fire   = ctl.load;
  assign cfg_ready = 1'b1;
  assign top_bits  = in_sample[SAMPLE_W-1:SAMPLE_SHIFT];

  frvd_seq #(
    .DIV_STEPS  (QREG_W),
    .ROOT_STEPS (ROOT_W)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .close    (close_r),
    .out_busy (out_valid_r & ~out_ready),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= '0;
      hang_r   <= HANG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: thresh_r <= cfg_data[THR_W-1:0];
        REG_HANGOVER:  hang_r   <= cfg_data[HANG_W-1:0];
        default: ;
      endcase
    end
  end

  // divide step: bring down the next dividend bit, try the divisor
  assign div_trial  = {rem_r[REM_W-2:0], quo_r[QREG_W-1]};
  // root step: bring down two radicand bits, try 4*root + 1
  assign root_take  = {rem_r[REM_W-3:0], quo_r[2*ROOT_W-1 -: 2]};
  assign root_trial = REM_W'({root_r, 2'b01});

  // operand select for the shared unit
  always_comb begin
    alu_a   = ALU_W'(sum_r);
    alu_b   = ALU_W'(sq_r);
    alu_sub = 1'b0;
    if (ctl.divide) begin
      alu_a   = ALU_W'(div_trial);
      alu_b   = ALU_W'(div_r);
      alu_sub = 1'b1;
    end else if (ctl.root) begin
      alu_a   = ALU_W'(root_take);
      alu_b   = ALU_W'(root_trial);
      alu_sub = 1'b1;
    end
  end

  frvd_alu #(
    .W (ALU_W)
  ) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  // magnitude and square; the square is registered in S_SQUARE and feeds the adder in S_ACCUM
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mag_r <= top_bits[MAG_W-1] ? (~top_bits + 1'b1) : top_bits;
    end
    if (ctl.square) begin
      sq_r <= SQ_W'(mag_r * mag_r);
    end
  end

  // voice decision, evaluated in the emit cycle
  always_comb begin
    vnow         = (root_r > ROOT_W'(thresh_r));
    vstart       = 1'b0;
    vend         = 1'b0;
    speaking_nxt = speaking_r;
    silence_nxt  = silence_r;
    if (vnow) begin
      silence_nxt = '0;
      if (!speaking_r) begin
        speaking_nxt = 1'b1;
        vstart       = 1'b1;
      end
    end else if (speaking_r) begin
      if (silence_r != SIL_MAX) begin
        silence_nxt = silence_r + 1'b1;
      end
      // hangover reached ends speech, silence count kept until next voice
      if (silence_nxt >= hang_r) begin
        speaking_nxt = 1'b0;
        vend         = 1'b1;
      end
    end
  end

  // datapath next state
  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    div_nxt   = div_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    if (in_fire) begin
      count_nxt = count_r + 1'b1;
    end
    if (ctl.accum) begin
      if (close_r) begin
        // frame closes: sum moves into the divide shift register
        quo_nxt   = QREG_W'(alu_res[SUM_W-1:0]);
        sum_nxt   = '0;
        div_nxt   = count_r;
        count_nxt = '0;
        rem_nxt   = '0;
      end else begin
        sum_nxt = alu_res[SUM_W-1:0];
      end
    end
    if (ctl.divide) begin
      quo_nxt = {quo_r[QREG_W-2:0], ~alu_borrow};
      rem_nxt = alu_borrow ? div_trial : alu_res[REM_W-1:0];
      if (ctl.div_last) begin
        rem_nxt  = '0;
        root_nxt = '0;
      end
    end
    if (ctl.root) begin
      quo_nxt  = {quo_r[QREG_W-3:0], 2'b00};
      rem_nxt  = alu_borrow ? root_take : alu_res[REM_W-1:0];
      root_nxt = {root_r[ROOT_W-2:0], ~alu_borrow};
    end
  end

  always_ff @(posedge clk) begin
    div_r  <= div_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    if (in_fire) begin
      // overlong frame closes exactly as if frame_last were set
      close_r <= in_frame_last | (count_r == CNT_W'(FRAME_MAX - 1));
    end
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

  // detector state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speaking_r  <= 1'b0;
      silence_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.emit) begin
        speaking_r  <= speaking_nxt;
        silence_r   <= silence_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (ctl.emit) begin
      out_level_r <= LEVEL_W'(root_r);
      out_now_r   <= vnow;
      out_start_r <= vstart;
      out_end_r   <= vend;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_level       = out_level_r;
  assign out_voice_now   = out_now_r;
  assign out_voice_start = out_start_r;
  assign out_voice_end   = out_end_r;

  // checks
  `FRVD_ASSERT_NOW(a_count_in_range, in_ready, count_r < CNT_W'(FRAME_MAX), "frame count overran")
  `FRVD_ASSERT_NOW(a_start_has_voice, out_valid && out_voice_start, out_voice_now, "start without voice")
  `FRVD_ASSERT_NOW(a_end_is_quiet, out_valid && out_voice_end, !out_voice_now && !out_voice_start, "end on voice frame")
  `FRVD_ASSERT_NEXT(a_emit_shows, ctl.emit, out_valid && (out_voice_start == $past(vstart)), "emit not registered")

endmodule

`default_nettype wire
